@@ hdl/xsr_pkg.sv @@
// Package with the command type, generator constants and rotate helper for the PRNG block.
package xsr_pkg;

  typedef enum logic {
    CMD_SEED = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_t;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  localparam int unsigned MIX_SHIFT_A = 30;
  localparam int unsigned MIX_SHIFT_B = 27;
  localparam int unsigned MIX_SHIFT_C = 31;
  localparam int unsigned XOR_SHIFT   = 17;
  localparam int unsigned STATE_ROT   = 45;
  localparam int unsigned OUT_ROT     = 7;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned amount);
    return (v << amount) | (v >> (64 - amount));
  endfunction

endpackage

@@ hdl/xsr_front.sv @@
// Front end: accepts items, classifies them into commands and queues them for the back end.
module xsr_front #(
  parameter int RANGE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_opcode,
  input  logic [63:0]            in_seed_value,
  input  logic [RANGE_WIDTH-1:0] in_range_min,
  input  logic [RANGE_WIDTH-1:0] in_range_max,
  output logic                   q_valid,
  input  logic                   q_pop,
  output xsr_pkg::cmd_t          q_cmd,
  output logic [63:0]            q_seed,
  output logic [RANGE_WIDTH-1:0] q_lo,
  output logic [RANGE_WIDTH-1:0] q_hi
);

  localparam int DEPTH = 2;

  typedef struct packed {
    xsr_pkg::cmd_t          cmd;
    logic [63:0]            seed;
    logic [RANGE_WIDTH-1:0] lo;
    logic [RANGE_WIDTH-1:0] hi;
  } entry_t;

  entry_t      mem_r [DEPTH];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  entry_t      entry_in;

  assign in_stall = (cnt_r == 2'(DEPTH));
  assign push     = in_valid && !in_stall;

  always_comb begin
    entry_in.cmd  = in_opcode ? xsr_pkg::CMD_DRAW : xsr_pkg::CMD_SEED;
    entry_in.seed = in_seed_value;
    entry_in.lo   = in_range_min;
    entry_in.hi   = in_range_max;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rd_ptr_r].cmd;
  assign q_seed  = mem_r[rd_ptr_r].seed;
  assign q_lo    = mem_r[rd_ptr_r].lo;
  assign q_hi    = mem_r[rd_ptr_r].hi;

endmodule

@@ hdl/xsr_back.sv @@
// Back end: splitmix64 seeding, xoshiro256** draw, bit-serial range reduction and output register.
module xsr_back #(
  parameter int RANGE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  xsr_pkg::cmd_t          q_cmd,
  input  logic [63:0]            q_seed,
  input  logic [RANGE_WIDTH-1:0] q_lo,
  input  logic [RANGE_WIDTH-1:0] q_hi,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [63:0]            out_raw_value,
  output logic [RANGE_WIDTH-1:0] out_ranged_value,
  output logic                   out_range_error
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_MIX_ADD  = 9'b000000010,
    ST_MUL      = 9'b000000100,
    ST_MIX_B    = 9'b000001000,
    ST_MIX_OUT  = 9'b000010000,
    ST_SCRAMBLE = 9'b000100000,
    ST_RAW      = 9'b001000000,
    ST_MOD      = 9'b010000000,
    ST_OUT      = 9'b100000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic [63:0]            mul_a_r, mul_a_nxt;
  logic                   mul_second_r, mul_second_nxt;
  logic [1:0]             mul_ph_r, mul_ph_nxt;
  logic [63:0]            prod_r, prod_nxt;
  logic [63:0]            w_r [4];
  logic [63:0]            w_nxt [4];
  logic [63:0]            t_r, t_nxt;
  logic [63:0]            raw_r, raw_nxt;
  logic [63:0]            div_r, div_nxt;
  logic [RANGE_WIDTH-1:0] rem_r, rem_nxt;
  logic [RANGE_WIDTH:0]   span_r, span_nxt;
  logic [RANGE_WIDTH-1:0] lo_r, lo_nxt;
  logic                   err_r, err_nxt;
  logic [5:0]             cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [63:0]            out_raw_r, out_raw_nxt;
  logic [RANGE_WIDTH-1:0] out_ranged_r, out_ranged_nxt;
  logic                   out_err_r, out_err_nxt;

  logic [63:0]            mul_b;
  logic [31:0]            mul_x;
  logic [31:0]            mul_y;
  logic [63:0]            mul_p;
  logic [63:0]            mix_sum;
  logic [63:0]            rot_t;
  logic [RANGE_WIDTH:0]   trial;
  logic [RANGE_WIDTH:0]   trial_diff;

  always_comb begin
    mul_b = mul_second_r ? xsr_pkg::MIX_MUL_B : xsr_pkg::MIX_MUL_A;
    unique case (mul_ph_r)
      2'd0:    begin mul_x = mul_a_r[31:0];  mul_y = mul_b[31:0];  end
      2'd1:    begin mul_x = mul_a_r[31:0];  mul_y = mul_b[63:32]; end
      default: begin mul_x = mul_a_r[63:32]; mul_y = mul_b[31:0];  end
    endcase
    mul_p = 64'(mul_x) * 64'(mul_y);
  end

  assign mix_sum    = acc_r + xsr_pkg::GOLDEN_STEP;
  assign rot_t      = xsr_pkg::rotl64(t_r, xsr_pkg::OUT_ROT);
  assign trial      = {rem_r, div_r[63]};
  assign trial_diff = trial - span_r;

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    idx_nxt        = idx_r;
    mul_a_nxt      = mul_a_r;
    mul_second_nxt = mul_second_r;
    mul_ph_nxt     = mul_ph_r;
    prod_nxt       = prod_r;
    for (int i = 0; i < 4; i++) begin
      w_nxt[i] = w_r[i];
    end
    t_nxt          = t_r;
    raw_nxt        = raw_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    span_nxt       = span_r;
    lo_nxt         = lo_r;
    err_nxt        = err_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_raw_nxt    = out_raw_r;
    out_ranged_nxt = out_ranged_r;
    out_err_nxt    = out_err_r;
    q_pop          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd == xsr_pkg::CMD_SEED) begin
            acc_nxt   = q_seed;
            idx_nxt   = 2'd0;
            state_nxt = ST_MIX_ADD;
          end else begin
            lo_nxt    = q_lo;
            span_nxt  = {1'b0, q_hi} - {1'b0, q_lo} + (RANGE_WIDTH+1)'(1);
            err_nxt   = (q_hi < q_lo);
            state_nxt = ST_SCRAMBLE;
          end
        end
      end
      ST_MIX_ADD: begin
        acc_nxt        = mix_sum;
        mul_a_nxt      = mix_sum ^ (mix_sum >> xsr_pkg::MIX_SHIFT_A);
        mul_second_nxt = 1'b0;
        mul_ph_nxt     = 2'd0;
        state_nxt      = ST_MUL;
      end
      ST_MUL: begin
        if (mul_ph_r == 2'd0) begin
          prod_nxt = mul_p;
        end else begin
          prod_nxt = {prod_r[63:32] + mul_p[31:0], prod_r[31:0]};
        end
        if (mul_ph_r == 2'd2) begin
          mul_ph_nxt = 2'd0;
          state_nxt  = mul_second_r ? ST_MIX_OUT : ST_MIX_B;
        end else begin
          mul_ph_nxt = mul_ph_r + 2'd1;
        end
      end
      ST_MIX_B: begin
        mul_a_nxt      = prod_r ^ (prod_r >> xsr_pkg::MIX_SHIFT_B);
        mul_second_nxt = 1'b1;
        state_nxt      = ST_MUL;
      end
      ST_MIX_OUT: begin
        w_nxt[idx_r] = prod_r ^ (prod_r >> xsr_pkg::MIX_SHIFT_C);
        idx_nxt      = idx_r + 2'd1;
        state_nxt    = (idx_r == 2'd3) ? ST_IDLE : ST_MIX_ADD;
      end
      ST_SCRAMBLE: begin
        t_nxt     = (w_r[1] << 2) + w_r[1];
        w_nxt[0]  = w_r[0] ^ w_r[3] ^ w_r[1];
        w_nxt[1]  = w_r[1] ^ w_r[2] ^ w_r[0];
        w_nxt[2]  = w_r[2] ^ w_r[0] ^ (w_r[1] << xsr_pkg::XOR_SHIFT);
        w_nxt[3]  = xsr_pkg::rotl64(w_r[3] ^ w_r[1], xsr_pkg::STATE_ROT);
        state_nxt = ST_RAW;
      end
      ST_RAW: begin
        raw_nxt   = (rot_t << 3) + rot_t;
        div_nxt   = (rot_t << 3) + rot_t;
        rem_nxt   = '0;
        cnt_nxt   = 6'd63;
        state_nxt = err_r ? ST_OUT : ST_MOD;
      end
      ST_MOD: begin
        if (trial >= span_r) begin
          rem_nxt = trial_diff[RANGE_WIDTH-1:0];
        end else begin
          rem_nxt = trial[RANGE_WIDTH-1:0];
        end
        div_nxt = div_r << 1;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_raw_nxt    = raw_r;
          out_ranged_nxt = err_r ? '0 : lo_r + rem_r;
          out_err_nxt    = err_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_MIX_ADD;
      acc_r        <= '0;
      idx_r        <= 2'd0;
      mul_second_r <= 1'b0;
      mul_ph_r     <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      acc_r        <= acc_nxt;
      idx_r        <= idx_nxt;
      mul_second_r <= mul_second_nxt;
      mul_ph_r     <= mul_ph_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_a_r      <= mul_a_nxt;
    prod_r       <= prod_nxt;
    for (int i = 0; i < 4; i++) begin
      w_r[i] <= w_nxt[i];
    end
    t_r          <= t_nxt;
    raw_r        <= raw_nxt;
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    span_r       <= span_nxt;
    lo_r         <= lo_nxt;
    err_r        <= err_nxt;
    cnt_r        <= cnt_nxt;
    out_raw_r    <= out_raw_nxt;
    out_ranged_r <= out_ranged_nxt;
    out_err_r    <= out_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_raw_value    = out_raw_r;
  assign out_ranged_value = out_ranged_r;
  assign out_range_error  = out_err_r;

endmodule

@@ hdl/xoshiro256ss_prng_with_range.sv @@
// Top level of the xoshiro256** generator with splitmix64 seeding and a ranged draw.
//
// The input channel takes one item per handshake: a reseed item (opcode 0) expands
// seed_value into the four state words and gives no result; a draw item (opcode 1)
// returns the scrambled 64-bit output and that value reduced into [range_min, range_max].
// An inverted range sets range_error and gives a ranged value of zero.
// A two-entry queue sits between the input channel and the engine, so up to two items
// can be taken while the engine is busy.
// A draw goes from the queue through the scramble and raw-output steps and the
// one-bit-per-cycle 64-bit remainder loop to its result register; an inverted range
// skips the loop. A reseed runs eight 64-bit multiplies on one shared 32x32
// multiplier, each built from partial products.
// After reset the engine first expands seed zero; items are queued meanwhile.
// The result sits in an output register until taken; while the receiver stalls, the
// engine finishes its current item and holds it, and the queue fills and then stalls
// the input channel.
module xoshiro256ss_prng_with_range #(
  parameter int RANGE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_opcode,
  input  logic [63:0]            in_seed_value,
  input  logic [RANGE_WIDTH-1:0] in_range_min,
  input  logic [RANGE_WIDTH-1:0] in_range_max,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [63:0]            out_raw_value,
  output logic [RANGE_WIDTH-1:0] out_ranged_value,
  output logic                   out_range_error
);

  logic                   q_valid;
  logic                   q_pop;
  xsr_pkg::cmd_t          q_cmd;
  logic [63:0]            q_seed;
  logic [RANGE_WIDTH-1:0] q_lo;
  logic [RANGE_WIDTH-1:0] q_hi;

  xsr_front #(
    .RANGE_WIDTH(RANGE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_seed_value(in_seed_value),
    .in_range_min (in_range_min),
    .in_range_max (in_range_max),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_cmd        (q_cmd),
    .q_seed       (q_seed),
    .q_lo         (q_lo),
    .q_hi         (q_hi)
  );

  xsr_back #(
    .RANGE_WIDTH(RANGE_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_cmd           (q_cmd),
    .q_seed          (q_seed),
    .q_lo            (q_lo),
    .q_hi            (q_hi),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_raw_value   (out_raw_value),
    .out_ranged_value(out_ranged_value),
    .out_range_error (out_range_error)
  );

endmodule

@@ sim/tb.sv @@
// Testbench for the xoshiro256** generator with splitmix64 seeding and ranged draws.
module tb;

  localparam int RW = 16;

  typedef struct packed {
    xsr_pkg::cmd_t op;
    logic [63:0]   seed;
    logic [RW-1:0] lo;
    logic [RW-1:0] hi;
  } req_t;

  typedef struct packed {
    logic [63:0]   raw;
    logic [RW-1:0] ranged;
    logic          err;
  } draw_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          in_opcode = 1'b0;
  logic [63:0]   in_seed_value = '0;
  logic [RW-1:0] in_range_min = '0;
  logic [RW-1:0] in_range_max = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [63:0]   out_raw_value;
  logic [RW-1:0] out_ranged_value;
  logic          out_range_error;

  req_t        cmd_backlog[$];
  draw_t       draws_due[$];
  logic [63:0] gen_words[4];
  bit          in_taken = 1'b0;
  int          n_accepted = 0;
  int          errors = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  xoshiro256ss_prng_with_range #(.RANGE_WIDTH(RW)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_seed_value(in_seed_value),
    .in_range_min(in_range_min),
    .in_range_max(in_range_max),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_raw_value(out_raw_value),
    .out_ranged_value(out_ranged_value),
    .out_range_error(out_range_error)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("tb failed");
    $finish;
  end

  function automatic int idle_pct();
    return (n_accepted >= 350 && n_accepted < 470) ? 0 : 27;
  endfunction

  function automatic logic [63:0] mix64(input logic [63:0] z);
    z = (z ^ (z >> xsr_pkg::MIX_SHIFT_A)) * xsr_pkg::MIX_MUL_A;
    z = (z ^ (z >> xsr_pkg::MIX_SHIFT_B)) * xsr_pkg::MIX_MUL_B;
    return z ^ (z >> xsr_pkg::MIX_SHIFT_C);
  endfunction

  task automatic expand_seed(input logic [63:0] seed);
    logic [63:0] acc;
    acc = seed;
    for (int i = 0; i < 4; i++) begin
      acc = acc + xsr_pkg::GOLDEN_STEP;
      gen_words[i] = mix64(acc);
    end
  endtask

  task automatic apply_item(input req_t r);
    draw_t       d;
    logic [63:0] m;
    logic [63:0] t;
    logic [63:0] rem;
    logic [16:0] span;
    if (r.op == xsr_pkg::CMD_SEED) begin
      expand_seed(r.seed);
    end else begin
      m = gen_words[1] * 64'd5;
      m = {m[56:0], m[63:57]};
      d.raw = m * 64'd9;
      t = gen_words[1] << xsr_pkg::XOR_SHIFT;
      gen_words[2] = gen_words[2] ^ gen_words[0];
      gen_words[3] = gen_words[3] ^ gen_words[1];
      gen_words[1] = gen_words[1] ^ gen_words[2];
      gen_words[0] = gen_words[0] ^ gen_words[3];
      gen_words[2] = gen_words[2] ^ t;
      gen_words[3] = {gen_words[3][18:0], gen_words[3][63:19]};
      if (r.hi < r.lo) begin
        d.ranged = '0;
        d.err = 1'b1;
      end else begin
        span = {1'b0, r.hi} - {1'b0, r.lo} + 17'd1;
        rem = d.raw % {47'd0, span};
        d.ranged = r.lo + rem[RW-1:0];
        d.err = 1'b0;
      end
      draws_due.push_back(d);
    end
  endtask

  task automatic add_req(input xsr_pkg::cmd_t op, input logic [63:0] seed,
                         input logic [RW-1:0] lo, input logic [RW-1:0] hi);
    req_t r;
    r.op = op;
    r.seed = seed;
    r.lo = lo;
    r.hi = hi;
    cmd_backlog.push_back(r);
  endtask

  always @(negedge clk) begin : drive_in
    req_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (cmd_backlog.size() > 0 && $urandom_range(99) >= idle_pct()) begin
        nxt = cmd_backlog.pop_front();
        in_opcode <= nxt.op;
        in_seed_value <= nxt.seed;
        in_range_min <= nxt.lo;
        in_range_max <= nxt.hi;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_out_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && n_accepted >= 150) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (idle_pct() != 0) && ($urandom_range(99) < 27);
    end
  end

  always @(posedge clk) begin : take_in
    req_t r;
    if (!rst_n) begin
      expand_seed(64'd0);
      in_taken = 1'b0;
    end else if (in_valid && !in_stall) begin
      r.op = xsr_pkg::cmd_t'(in_opcode);
      r.seed = in_seed_value;
      r.lo = in_range_min;
      r.hi = in_range_max;
      apply_item(r);
      n_accepted = n_accepted + 1;
      in_taken = 1'b1;
    end else begin
      in_taken = 1'b0;
    end
  end

  always @(posedge clk) begin : check_out
    draw_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (draws_due.size() == 0) begin
        $display("%0t: unexpected item raw %h ranged %h error %b", $time,
                 out_raw_value, out_ranged_value, out_range_error);
        errors++;
      end else begin
        want = draws_due.pop_front();
        if (out_raw_value !== want.raw) begin
          $display("%0t: raw_value expected %h actual %h", $time, want.raw, out_raw_value);
          errors++;
        end
        if (out_ranged_value !== want.ranged) begin
          $display("%0t: ranged_value expected %h actual %h", $time, want.ranged,
                   out_ranged_value);
          errors++;
        end
        if (out_range_error !== want.err) begin
          $display("%0t: range_error expected %b actual %b", $time, want.err,
                   out_range_error);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [RW-1:0] lo;
    logic [RW-1:0] hi;
    logic [RW-1:0] top;
    top = '1;

    add_req(xsr_pkg::CMD_DRAW, 64'd0, '0, top);
    add_req(xsr_pkg::CMD_DRAW, '1, '0, '0);
    add_req(xsr_pkg::CMD_DRAW, 64'd0, top, top);
    add_req(xsr_pkg::CMD_DRAW, 64'd0, top, '0);
    add_req(xsr_pkg::CMD_DRAW, 64'd0, RW'(1), '0);
    add_req(xsr_pkg::CMD_DRAW, 64'd0, '0, RW'(1));
    add_req(xsr_pkg::CMD_SEED, 64'd0, top, '0);
    add_req(xsr_pkg::CMD_DRAW, 64'd0, '0, top);
    add_req(xsr_pkg::CMD_SEED, '1, '0, top);
    add_req(xsr_pkg::CMD_DRAW, '1, RW'(100), RW'(200));
    add_req(xsr_pkg::CMD_DRAW, 64'h5555_5555_5555_5555, RW'(16'h8000), top);
    add_req(xsr_pkg::CMD_SEED, 64'h8000_0000_0000_0000, '0, '0);
    add_req(xsr_pkg::CMD_SEED, 64'h0000_0000_0000_0001, '0, '0);
    add_req(xsr_pkg::CMD_DRAW, 64'd0, '0, RW'(16'h7fff));
    add_req(xsr_pkg::CMD_DRAW, 64'd0, RW'(16'h7fff), RW'(16'h8000));
    add_req(xsr_pkg::CMD_SEED, 64'haaaa_aaaa_aaaa_aaaa, RW'(16'h1234), RW'(16'h4321));
    add_req(xsr_pkg::CMD_DRAW, 64'd0, RW'(16'h8000), RW'(16'h7fff));
    add_req(xsr_pkg::CMD_DRAW, 64'd0, RW'(3), RW'(3));
    add_req(xsr_pkg::CMD_DRAW, 64'd0, '0, top);
    add_req(xsr_pkg::CMD_DRAW, 64'd0, RW'(1), top);

    for (int i = 0; i < 700; i++) begin
      if ($urandom_range(99) < 12) begin
        add_req(xsr_pkg::CMD_SEED, {$urandom, $urandom}, RW'($urandom), RW'($urandom));
      end else begin
        case ($urandom_range(4))
          0: begin
            lo = RW'($urandom);
            hi = RW'($urandom);
          end
          1: begin
            lo = RW'($urandom);
            hi = lo + RW'($urandom_range(15));
          end
          2: begin
            lo = '0;
            hi = RW'($urandom);
          end
          3: begin
            lo = RW'($urandom);
            hi = lo;
          end
          default: begin
            lo = '0;
            hi = top;
          end
        endcase
        add_req(xsr_pkg::CMD_DRAW, {$urandom, $urandom}, lo, hi);
      end
    end

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid) @(posedge clk);
    while (draws_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
